@@ hdl/ncs_pkg.sv @@
// Package for the nested comment stripper: constants, result and packet types.
// No dependencies; the modules of the block refer to it by scoped names.
package ncs_pkg;

    localparam int MAX_DEPTH   = 16;
    localparam int DEPTH_W     = $clog2(MAX_DEPTH + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] LINE_MAX = 16'hFFFF;
    localparam logic [11:0] COL_MAX  = 12'hFFF;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_NL    = 8'h0A;

    typedef enum logic [1:0] {
        ST_BYTE   = 2'd0,
        ST_END    = 2'd1,
        ST_UNTERM = 2'd2,
        ST_DEEP   = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [15:0] line_no;
        logic [11:0] column_no;
        t_status     status;
        logic        last_of_run;
    } t_res;

    // All results caused by one input beat: one or two of them.
    typedef struct packed {
        logic [1:0] cnt;
        t_res       r0;
        t_res       r1;
    } t_pkt;

    typedef struct packed {
        logic push;
        t_pkt pkt;
    } t_push;

    typedef struct packed {
        logic valid;
        t_pkt pkt;
    } t_head;

    localparam logic [1:0] PKT_TWO = 2'd2;

endpackage

@@ hdl/ncs_in_if.sv @@
// Input channel of the stripper: one source byte or an end mark per beat.
// Depends on nothing.
interface ncs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_input;

    modport source (output valid, output byte_in, output end_of_input, input ready);
    modport sink   (input valid, input byte_in, input end_of_input, output ready);
endinterface

@@ hdl/ncs_out_if.sv @@
// Output channel of the stripper: one delivered byte or status per beat.
// Depends on nothing.
interface ncs_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_out;
    logic [15:0] line_no;
    logic [11:0] column_no;
    logic [1:0]  status;
    logic        last_of_run;

    modport source (output valid, output byte_out, output line_no, output column_no,
                    output status, output last_of_run, input ready);
    modport sink   (input valid, input byte_out, input line_no, input column_no,
                    input status, input last_of_run, output ready);
endinterface

@@ hdl/nested_comment_stripper.sv @@
// Top level of the nested /+ +/ comment stripper: front end, packet queue, back end.
// Depends on ncs_pkg, ncs_in_if, ncs_out_if, ncs_front, ncs_queue and ncs_back.
// Each beat's results are registered in the queue. Throughput: one input beat per
// cycle while the queue is not full; an input that causes two results (a held
// slash plus a byte, or a slash plus a clean end) takes two output beats.
// Reset (synchronous, active low) clears position, nesting and the queue at once.
module nested_comment_stripper (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ncs_in_if.sink    i_in,
    ncs_out_if.source o_out
);

    ncs_pkg::t_push push;
    ncs_pkg::t_head head;
    logic           full;
    logic           pop;

    // Classify each byte, track line, column and nesting, and build the
    // packet of results that it causes. Stall input only when the queue fills.
    ncs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push)
    );

    // Hold up to four packets so the sink can stall without stopping input until the
    // queue is full; two-result packets drain at one beat per cycle while o_out is ready.
    ncs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    // Serialize each packet onto the output channel, one result per beat.
    ncs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

@@ hdl/ncs_front.sv @@
// Front end: accepts input beats, tracks position and nesting, builds result packets.
// Depends on ncs_pkg and ncs_in_if.
module ncs_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ncs_in_if.sink         i_in,
    input  logic           i_full,
    output ncs_pkg::t_push o_push
);

    logic [15:0]                r_line,  n_line;
    logic [11:0]                r_col,   n_col;
    logic                       r_held,  n_held;
    logic [15:0]                r_sline, n_sline;
    logic [11:0]                r_scol,  n_scol;
    logic [ncs_pkg::DEPTH_W-1:0] r_depth, n_depth;
    logic                       r_plus [ncs_pkg::MAX_DEPTH+1];
    logic                       n_plus [ncs_pkg::MAX_DEPTH+1];
    ncs_pkg::t_pkt              pkt;
    logic                       accept;

    function automatic ncs_pkg::t_pkt add_res(ncs_pkg::t_pkt p, logic [7:0] b,
                                              logic [15:0] ln, logic [11:0] col,
                                              ncs_pkg::t_status st);
        ncs_pkg::t_res r;
        ncs_pkg::t_pkt q;
        r.byte_out    = b;
        r.line_no     = ln;
        r.column_no   = col;
        r.status      = st;
        r.last_of_run = 1'b0;
        q = p;
        if (p.cnt == 2'd0) begin
            q.r0 = r;
        end else begin
            q.r1 = r;
        end
        q.cnt = p.cnt + 2'd1;
        return q;
    endfunction

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    always_comb begin
        logic [7:0]                  b;
        logic [ncs_pkg::DEPTH_W-1:0] d;
        logic                        fresh;
        b       = i_in.byte_in;
        n_line  = r_line;
        n_col   = r_col;
        n_held  = r_held;
        n_sline = r_sline;
        n_scol  = r_scol;
        n_depth = r_depth;
        n_plus  = r_plus;
        pkt     = '0;
        fresh   = 1'b0;
        d       = r_depth;

        if (i_in.end_of_input) begin
            if (r_depth == '0) begin
                if (r_held) begin
                    pkt = add_res(pkt, ncs_pkg::CH_SLASH, r_sline, r_scol, ncs_pkg::ST_BYTE);
                end
                pkt = add_res(pkt, 8'd0, r_line, r_col, ncs_pkg::ST_END);
            end else if (r_held) begin
                pkt = add_res(pkt, 8'd0, r_sline, r_scol, ncs_pkg::ST_UNTERM);
            end else begin
                pkt = add_res(pkt, 8'd0, r_line, r_col, ncs_pkg::ST_UNTERM);
            end
            // Return to the reset state after any end mark.
            n_line  = '0;
            n_col   = '0;
            n_held  = 1'b0;
            n_sline = '0;
            n_scol  = '0;
            n_depth = '0;
            for (int i = 0; i <= ncs_pkg::MAX_DEPTH; i++) begin
                n_plus[i] = 1'b0;
            end
        end else begin
            // Advance the position, saturating.
            if (b == ncs_pkg::CH_NL) begin
                if (r_line < ncs_pkg::LINE_MAX) begin
                    n_line = r_line + 16'd1;
                end
                n_col = '0;
            end else if (r_col < ncs_pkg::COL_MAX) begin
                n_col = r_col + 12'd1;
            end

            if (r_held) begin
                n_held = 1'b0;
                if (b == ncs_pkg::CH_PLUS) begin
                    if (r_depth < ncs_pkg::DEPTH_W'(ncs_pkg::MAX_DEPTH)) begin
                        n_depth         = r_depth + ncs_pkg::DEPTH_W'(1);
                        n_plus[n_depth] = 1'b0;
                    end else begin
                        n_plus[r_depth] = 1'b0;
                        pkt = add_res(pkt, 8'd0, r_sline, r_scol, ncs_pkg::ST_DEEP);
                    end
                end else begin
                    if (r_depth == '0) begin
                        pkt = add_res(pkt, ncs_pkg::CH_SLASH, r_sline, r_scol,
                                      ncs_pkg::ST_BYTE);
                    end else if (r_plus[r_depth]) begin
                        n_plus[r_depth] = 1'b0;
                        n_depth         = r_depth - ncs_pkg::DEPTH_W'(1);
                    end else begin
                        n_plus[r_depth] = 1'b0;
                    end
                    fresh = 1'b1;
                    d     = n_depth;
                end
            end else begin
                fresh = 1'b1;
            end

            if (fresh) begin
                if (b == ncs_pkg::CH_SLASH) begin
                    n_held  = 1'b1;
                    n_sline = r_line;
                    n_scol  = r_col;
                end else if (d == '0) begin
                    pkt = add_res(pkt, b, r_line, r_col, ncs_pkg::ST_BYTE);
                end else begin
                    n_plus[d] = (b == ncs_pkg::CH_PLUS);
                end
            end
        end

        // Mark the final result of this beat.
        if (pkt.cnt == ncs_pkg::PKT_TWO) begin
            pkt.r1.last_of_run = 1'b1;
        end else begin
            pkt.r0.last_of_run = 1'b1;
        end
    end

    assign o_push.push = accept && (pkt.cnt != 2'd0);
    assign o_push.pkt  = pkt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line  <= '0;
            r_col   <= '0;
            r_held  <= 1'b0;
            r_sline <= '0;
            r_scol  <= '0;
            r_depth <= '0;
            for (int i = 0; i <= ncs_pkg::MAX_DEPTH; i++) begin
                r_plus[i] <= 1'b0;
            end
        end else if (accept) begin
            r_line  <= n_line;
            r_col   <= n_col;
            r_held  <= n_held;
            r_sline <= n_sline;
            r_scol  <= n_scol;
            r_depth <= n_depth;
            r_plus  <= n_plus;
        end
    end

endmodule

@@ hdl/ncs_queue.sv @@
// Short packet queue between front and back ends of the stripper.
// Depends on ncs_pkg.
module ncs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ncs_pkg::t_push i_push,
    input  logic           i_pop,
    output logic           o_full,
    output ncs_pkg::t_head o_head
);

    ncs_pkg::t_pkt               r_mem [ncs_pkg::QUEUE_DEPTH];
    logic [ncs_pkg::QPTR_W-1:0]  r_wptr;
    logic [ncs_pkg::QPTR_W-1:0]  r_rptr;
    logic [ncs_pkg::QCNT_W-1:0]  r_count;
    logic                        do_push;
    logic                        do_pop;

    assign o_full       = (r_count == ncs_pkg::QCNT_W'(ncs_pkg::QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.pkt   = r_mem[r_rptr];
    assign do_push      = i_push.push && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push.pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + ncs_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + ncs_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + ncs_pkg::QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - ncs_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

@@ hdl/ncs_back.sv @@
// Back end: splits each queued packet into one or two output beats.
// Depends on ncs_pkg and ncs_out_if.
module ncs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ncs_pkg::t_head i_head,
    output logic           o_pop,
    ncs_out_if.source      o_out
);

    logic          r_sub;
    ncs_pkg::t_res item;
    logic          fire;

    assign item  = r_sub ? i_head.pkt.r1 : i_head.pkt.r0;
    assign fire  = i_head.valid && o_out.ready;
    // Drop the packet once its last result leaves.
    assign o_pop = fire && (r_sub || (i_head.pkt.cnt != ncs_pkg::PKT_TWO));

    assign o_out.valid       = i_head.valid;
    assign o_out.byte_out    = item.byte_out;
    assign o_out.line_no     = item.line_no;
    assign o_out.column_no   = item.column_no;
    assign o_out.status      = item.status;
    assign o_out.last_of_run = item.last_of_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= 1'b0;
        end else if (fire) begin
            r_sub <= !o_pop;
        end
    end

endmodule
